/* rtl/core/graph_bfs_distance_check_unit_defines.svh */
// ----------------------------------------------------------------------------
// graph bfs distance check: assertion macros
// shared property shapes for the checker files
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DISTANCE_CHECK_UNIT_DEFINES_SVH
`define GRAPH_BFS_DISTANCE_CHECK_UNIT_DEFINES_SVH

// same-cycle implication
`define GBDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gbdc_pkg.sv */
// ----------------------------------------------------------------------------
// gbdc_pkg
// types and codes shared by the bfs distance check unit
// ----------------------------------------------------------------------------
package gbdc_pkg;

  localparam int NODE_FIELD_W = 6;
  localparam int DIST_W       = 6;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [DIST_W-1:0]       hop_limit;
  } item_t;

  typedef struct packed {
    logic              within_res;
    logic              reachable;
    logic [DIST_W-1:0] hop_distance;
  } result_t;

  typedef enum logic [1:0] {
    ROW_HOLD,
    ROW_CLEAR,
    ROW_LOAD_BIT,
    ROW_OR
  } row_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_A_RD,
    S_ADD_A_MRG,
    S_ADD_A_WR,
    S_ADD_B_RD,
    S_ADD_B_MRG,
    S_ADD_B_WR,
    S_Q_CHECK,
    S_Q_SCAN,
    S_Q_DRAIN,
    S_Q_NEXT,
    S_RESP
  } state_e;

endpackage

/* rtl/core/graph_bfs_distance_check_unit.sv */
// ----------------------------------------------------------------------------
// graph_bfs_distance_check_unit
// adjacency bit matrix in ram, edge add, clear and bfs hop distance query
// ----------------------------------------------------------------------------
//  channel  | signals                            | payload
//  ---------+------------------------------------+-----------------------
//  item     | item_valid, item_ready, item       | gbdc_pkg::item_t
//  result   | result_valid, result_ready, result | gbdc_pkg::result_t
//
//  add edge: read, merge, write for each endpoint, then answer and back to idle.
//  clear, other commands and out-of-range nodes go straight to answer and back to idle.
//  query: a search runs in levels; each level is a check, NODES row reads
//  through the shared row unit, a drain and a step.
//  reset and clear empty the graph at once through per-row valid bits, no sweep.
//  item_ready is high only when idle; a held result lets one more item run,
//  which then waits in its answer state with item_ready low.
// ----------------------------------------------------------------------------
module graph_bfs_distance_check_unit #(
  parameter int NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  gbdc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output gbdc_pkg::result_t result
);

  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
  localparam logic [NODES-1:0]  ONE_BIT   = NODES'(1);

  gbdc_pkg::state_e  state, state_next;
  gbdc_pkg::item_t   cur;
  gbdc_pkg::result_t res;

  logic [NODES-1:0]  row_valid;
  logic [NODES-1:0]  seen;
  logic [NODES-1:0]  front;
  logic [NODE_W-1:0] level;
  logic [NODE_W-1:0] scan;
  logic              pend;
  logic              pend_front;
  logic              rd_valid;

  logic [NODE_W-1:0] idx_a, idx_b, in_idx_a;
  logic              in_a_ok, in_b_ok;
  logic              accept, found;

  logic              ram_we, ram_re;
  logic [NODE_W-1:0] ram_waddr, ram_raddr;
  logic [NODES-1:0]  ram_rdata;

  gbdc_pkg::row_op_e row_op;
  logic [NODES-1:0]  bit_mask;
  logic [NODES-1:0]  acc, fresh;
  logic              fresh_any;

  assign idx_a    = NODE_W'(cur.node_a);
  assign idx_b    = NODE_W'(cur.node_b);
  assign in_idx_a = NODE_W'(item.node_a);
  assign in_a_ok  = int'(item.node_a) < NODES;
  assign in_b_ok  = int'(item.node_b) < NODES;
  assign item_ready = (state == gbdc_pkg::S_IDLE);
  assign accept   = item_valid && item_ready;
  assign found    = front[idx_b];

  gbdc_ram #(
    .WIDTH (NODES),
    .DEPTH (NODES)
  ) u_adj (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (acc),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbdc_row_unit #(
    .NODES (NODES)
  ) u_row (
    .clk       (clk),
    .op        (row_op),
    .rdata     (ram_rdata),
    .rd_valid  (rd_valid),
    .bit_mask  (bit_mask),
    .seen      (seen),
    .acc       (acc),
    .fresh     (fresh),
    .fresh_any (fresh_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx_a;
    ram_re     = 1'b0;
    ram_raddr  = idx_a;
    row_op     = gbdc_pkg::ROW_HOLD;
    bit_mask   = ONE_BIT << idx_b;
    unique case (state)
      gbdc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.cmd)
            gbdc_pkg::CMD_ADD: begin
              state_next = (in_a_ok && in_b_ok) ? gbdc_pkg::S_ADD_A_RD
                                                : gbdc_pkg::S_RESP;
            end
            gbdc_pkg::CMD_QUERY: begin
              state_next = (in_a_ok && in_b_ok) ? gbdc_pkg::S_Q_CHECK
                                                : gbdc_pkg::S_RESP;
            end
            default: state_next = gbdc_pkg::S_RESP;
          endcase
        end
      end
      gbdc_pkg::S_ADD_A_RD: begin
        ram_re     = 1'b1;
        state_next = gbdc_pkg::S_ADD_A_MRG;
      end
      gbdc_pkg::S_ADD_A_MRG: begin
        row_op     = gbdc_pkg::ROW_LOAD_BIT;
        state_next = gbdc_pkg::S_ADD_A_WR;
      end
      gbdc_pkg::S_ADD_A_WR: begin
        ram_we     = 1'b1;
        state_next = gbdc_pkg::S_ADD_B_RD;
      end
      gbdc_pkg::S_ADD_B_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx_b;
        state_next = gbdc_pkg::S_ADD_B_MRG;
      end
      gbdc_pkg::S_ADD_B_MRG: begin
        row_op     = gbdc_pkg::ROW_LOAD_BIT;
        bit_mask   = ONE_BIT << idx_a;
        state_next = gbdc_pkg::S_ADD_B_WR;
      end
      gbdc_pkg::S_ADD_B_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx_b;
        state_next = gbdc_pkg::S_RESP;
      end
      gbdc_pkg::S_Q_CHECK: begin
        if (found) begin
          state_next = gbdc_pkg::S_RESP;
        end else begin
          row_op     = gbdc_pkg::ROW_CLEAR;
          state_next = gbdc_pkg::S_Q_SCAN;
        end
      end
      gbdc_pkg::S_Q_SCAN: begin
        // read row scan, merge the row from the previous read
        ram_re    = 1'b1;
        ram_raddr = scan;
        row_op    = (pend && pend_front) ? gbdc_pkg::ROW_OR : gbdc_pkg::ROW_HOLD;
        if (scan == LAST_NODE) begin
          state_next = gbdc_pkg::S_Q_DRAIN;
        end
      end
      gbdc_pkg::S_Q_DRAIN: begin
        row_op     = (pend && pend_front) ? gbdc_pkg::ROW_OR : gbdc_pkg::ROW_HOLD;
        state_next = gbdc_pkg::S_Q_NEXT;
      end
      gbdc_pkg::S_Q_NEXT: begin
        state_next = fresh_any ? gbdc_pkg::S_Q_CHECK : gbdc_pkg::S_RESP;
      end
      gbdc_pkg::S_RESP: begin
        if (!result_valid || result_ready) begin
          state_next = gbdc_pkg::S_IDLE;
        end
      end
      default: state_next = gbdc_pkg::S_IDLE;
    endcase
  end

  // row valid bits and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept && item.cmd == gbdc_pkg::CMD_CLEAR) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == gbdc_pkg::S_RESP && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    pend       <= (state == gbdc_pkg::S_Q_SCAN);
    pend_front <= front[scan];
    if (ram_re) begin
      rd_valid <= row_valid[ram_raddr];
    end
    if (accept) begin
      cur   <= item;
      res   <= '0;
      level <= '0;
      seen  <= ONE_BIT << in_idx_a;
      front <= ONE_BIT << in_idx_a;
    end
    if (state == gbdc_pkg::S_Q_CHECK) begin
      scan <= '0;
      if (found) begin
        res.reachable    <= 1'b1;
        res.within_res   <= int'(level) <= int'(cur.hop_limit);
        res.hop_distance <= gbdc_pkg::DIST_W'(level);
      end
    end
    if (state == gbdc_pkg::S_Q_SCAN) begin
      scan <= scan + NODE_W'(1);
    end
    if (state == gbdc_pkg::S_Q_NEXT && fresh_any) begin
      seen  <= seen | fresh;
      front <= fresh;
      level <= level + NODE_W'(1);
    end
    if (state == gbdc_pkg::S_RESP && (!result_valid || result_ready)) begin
      result <= res;
    end
  end

endmodule

/* rtl/core/gbdc_ram.sv */
// ----------------------------------------------------------------------------
// gbdc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gbdc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/gbdc_row_unit.sv */
// ----------------------------------------------------------------------------
// gbdc_row_unit
// shared row merge unit: one adjacency row per cycle, as op selects, into an accumulator
// ----------------------------------------------------------------------------
module gbdc_row_unit #(
  parameter int NODES = 64
) (
  input  logic                 clk,
  input  gbdc_pkg::row_op_e    op,
  input  logic [NODES-1:0]     rdata,
  input  logic                 rd_valid,
  input  logic [NODES-1:0]     bit_mask,
  input  logic [NODES-1:0]     seen,
  output logic [NODES-1:0]     acc,
  output logic [NODES-1:0]     fresh,
  output logic                 fresh_any
);

  logic [NODES-1:0] row_eff;

  // a row never written since reset or clear reads as empty
  assign row_eff   = rd_valid ? rdata : '0;
  assign fresh     = acc & ~seen;
  assign fresh_any = |fresh;

  always_ff @(posedge clk) begin
    unique case (op)
      gbdc_pkg::ROW_HOLD:     acc <= acc;
      gbdc_pkg::ROW_CLEAR:    acc <= '0;
      gbdc_pkg::ROW_LOAD_BIT: acc <= row_eff | bit_mask;
      gbdc_pkg::ROW_OR:       acc <= acc | row_eff;
      default:                acc <= acc;
    endcase
  end

endmodule

/* rtl/core/gbdc_checker.sv */
// ----------------------------------------------------------------------------
// gbdc_checker
// port-level checks for the bfs distance check unit, bound to the top level
// ----------------------------------------------------------------------------
`include "graph_bfs_distance_check_unit_defines.svh"

module gbdc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input gbdc_pkg::result_t result
);

  `GBDC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat dropped or changed while stalled")

  `GBDC_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready, "item taken while a previous one is still in work")

  `GBDC_ASSERT_NOW(a_within_needs_reach, clk, rst, result_valid && result.within_res, result.reachable, "within set on an unreachable target")

  `GBDC_ASSERT_NOW(a_unreach_zero_dist, clk, rst, result_valid && !result.reachable, result.hop_distance == '0, "nonzero distance without a path")

endmodule

bind graph_bfs_distance_check_unit gbdc_checker u_gbdc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
